@@ hw/rtl/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants and types for the COBS stream encoder: group RAM geometry,
// front-to-back command format and byte source codes.
// ----------------------------------------------------------------------------
package cse_pkg;

  // group geometry: at most 254 data bytes per group, two banks
  localparam int unsigned GROUP_MAX      = 254;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned RAM_DEPTH      = 512;
  localparam int unsigned RAM_ADDR_W     = $clog2(RAM_DEPTH);
  localparam int unsigned POS_W          = 9;

  // result payload
  localparam int unsigned OUT_W          = 64;
  localparam int unsigned CNT_FIELD_W    = 4;
  localparam int unsigned BYTES_PER_RESULT_DEF = 8;

  // code byte of an empty final group
  localparam logic [7:0]  LONE_CODE      = 8'h01;

  // flush command handed from front to back
  typedef struct packed {
    logic             bank;
    logic [IDX_W-1:0] len;
    logic             extra;   // append a lone empty group after this one
    logic             eop;
  } cmd_t;

  // group RAM write from the front
  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } ram_wr_t;

  // bank handed back to the front once its last byte is read
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  // where an output byte comes from
  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_RAM,
    SRC_ONE
  } byte_src_t;

endpackage

@@ hw/rtl/cse_in_if.sv @@
// ----------------------------------------------------------------------------
// cse_in_if
// Input byte channel: raw packet byte plus end-of-packet mark.
// ----------------------------------------------------------------------------
interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

@@ hw/rtl/cse_out_if.sv @@
// ----------------------------------------------------------------------------
// cse_out_if
// Output word channel: up to eight encoded bytes with count and end flags.
// ----------------------------------------------------------------------------
interface cse_out_if;
  logic                             valid;
  logic                             ready;
  logic [cse_pkg::OUT_W-1:0]        out_bytes;
  logic [cse_pkg::CNT_FIELD_W-1:0]  byte_count;
  logic                             last_of_run;
  logic                             packet_done;

  modport source (output valid, output out_bytes, output byte_count,
                  output last_of_run, output packet_done, input ready);
  modport sink   (input valid, input out_bytes, input byte_count,
                  input last_of_run, input packet_done, output ready);
endinterface

@@ hw/rtl/cse_ram.sv @@
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/cse_front.sv @@
// ----------------------------------------------------------------------------
// cse_front
// Accepts packet bytes, stores nonzero bytes into the open group bank and
// issues a flush command on a zero byte, a full group or packet end.
// ----------------------------------------------------------------------------
module cse_front (
  input  logic               clk,
  input  logic               rst,
  cse_in_if.sink             byte_in,
  output cse_pkg::ram_wr_t   ram_wr,
  output logic               q_push,
  output cse_pkg::cmd_t      q_cmd,
  input  cse_pkg::bank_rel_t bank_rel
);
  import cse_pkg::*;

  logic             cur;
  logic [IDX_W-1:0] group_length;
  logic [1:0]       bank_busy;
  logic             cur_next;
  logic [IDX_W-1:0] group_length_next;
  logic [1:0]       bank_busy_next;
  logic             take;
  logic             nonzero;
  logic [IDX_W-1:0] grown;
  logic             flush;

  // accept only while the bank being filled is not still draining
  assign byte_in.ready = !bank_busy[cur];
  assign take          = byte_in.valid && byte_in.ready;
  assign nonzero       = (byte_in.data_byte != 8'h00);
  assign grown         = group_length + IDX_W'(1);
  assign flush         = take && (!nonzero || byte_in.end_of_packet ||
                                  (grown == IDX_W'(GROUP_MAX)));

  // store nonzero bytes at the next free slot of the open bank
  always_comb begin
    ram_wr.en   = take && nonzero;
    ram_wr.addr = {cur, group_length};
    ram_wr.data = byte_in.data_byte;
  end

  // classify the byte into a flush command
  always_comb begin
    q_push      = flush;
    q_cmd.bank  = cur;
    q_cmd.len   = nonzero ? grown : group_length;
    q_cmd.extra = !nonzero && byte_in.end_of_packet;
    q_cmd.eop   = byte_in.end_of_packet;
  end

  // group length, bank select and bank ownership
  always_comb begin
    cur_next          = cur;
    group_length_next = group_length;
    bank_busy_next    = bank_busy;
    if (bank_rel.en) begin
      bank_busy_next[bank_rel.bank] = 1'b0;
    end
    if (flush) begin
      group_length_next   = '0;
      cur_next            = !cur;
      bank_busy_next[cur] = 1'b1;
    end else if (take) begin
      group_length_next = grown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur          <= 1'b0;
      group_length <= '0;
      bank_busy    <= '0;
    end else begin
      cur          <= cur_next;
      group_length <= group_length_next;
      bank_busy    <= bank_busy_next;
    end
  end

endmodule

@@ hw/rtl/cse_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// cse_cmd_queue
// Two-entry queue of flush commands between front and back.
// ----------------------------------------------------------------------------
module cse_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cse_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          head_valid,
  output cse_pkg::cmd_t head_cmd,
  output logic          full
);
  import cse_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);
  assign head_cmd   = slot[rd_ptr];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/cse_back.sv @@
// ----------------------------------------------------------------------------
// cse_back
// Walks each flush command byte by byte (code, group data, optional lone
// code), reads group data from the RAM and packs bytes into result words.
// ----------------------------------------------------------------------------
module cse_back #(
  parameter int unsigned BYTES_PER_RESULT = cse_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  cse_pkg::cmd_t                 head_cmd,
  output logic                          pop,
  output logic                          rd_en,
  output logic [cse_pkg::RAM_ADDR_W-1:0] rd_addr,
  input  logic [7:0]                    rd_data,
  output cse_pkg::bank_rel_t            bank_rel,
  cse_out_if.source                     word_out
);
  import cse_pkg::*;

  localparam int unsigned CNT_W = $clog2(BYTES_PER_RESULT + 1);

  // issue stage
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;
  logic             a_last;
  logic             issue;
  byte_src_t        a_src;

  // byte stage
  logic             b_valid;
  byte_src_t        b_src;
  logic [7:0]       b_code;
  logic             b_last;
  logic             b_eop;
  logic             b_take;
  logic [7:0]       b_byte;

  // packer and output register
  logic [OUT_W-1:0] acc;
  logic [CNT_W-1:0] acc_cnt;
  logic [OUT_W-1:0] word;
  logic [CNT_W-1:0] new_cnt;
  logic             word_done;
  logic             out_free;

  assign total  = POS_W'(head_cmd.len) + POS_W'(1) + POS_W'(head_cmd.extra);
  assign a_last = (pos == total - POS_W'(1));

  // pick the source of the byte at the current position
  always_comb begin
    if (pos == '0) begin
      a_src = SRC_CODE;
    end else if (pos <= POS_W'(head_cmd.len)) begin
      a_src = SRC_RAM;
    end else begin
      a_src = SRC_ONE;
    end
  end

  assign out_free = !word_out.valid || word_out.ready;
  assign b_take   = b_valid && out_free;
  assign issue    = head_valid && (!b_valid || b_take);
  assign pop      = issue && a_last;

  // read data byte pos-1 of the command's bank
  assign rd_en   = issue && (a_src == SRC_RAM);
  assign rd_addr = {head_cmd.bank, pos[IDX_W-1:0] - IDX_W'(1)};

  // release the bank once its last read is issued
  always_comb begin
    bank_rel.en   = pop;
    bank_rel.bank = head_cmd.bank;
  end

  // advance the position within the command
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (issue) begin
      pos <= a_last ? '0 : pos + POS_W'(1);
    end
  end

  // byte stage: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  // byte stage: payload
  always_ff @(posedge clk) begin
    if (issue) begin
      b_src  <= a_src;
      b_code <= head_cmd.len + IDX_W'(1);
      b_last <= a_last;
      b_eop  <= head_cmd.eop;
    end
  end

  // resolve the byte value
  always_comb begin
    case (b_src)
      SRC_CODE: b_byte = b_code;
      SRC_RAM:  b_byte = rd_data;
      SRC_ONE:  b_byte = LONE_CODE;
      default:  b_byte = LONE_CODE;
    endcase
  end

  // append the byte to the word being packed
  always_comb begin
    word = acc;
    word[int'(acc_cnt) * 8 +: 8] = b_byte;
    new_cnt   = acc_cnt + CNT_W'(1);
    word_done = b_last || (new_cnt == CNT_W'(BYTES_PER_RESULT));
  end

  // packer accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      acc_cnt <= '0;
    end else if (b_take) begin
      if (word_done) begin
        acc     <= '0;
        acc_cnt <= '0;
      end else begin
        acc     <= word;
        acc_cnt <= new_cnt;
      end
    end
  end

  // output register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else if (b_take && word_done) begin
      word_out.valid <= 1'b1;
    end else if (word_out.ready) begin
      word_out.valid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (b_take && word_done) begin
      word_out.out_bytes   <= word;
      word_out.byte_count  <= CNT_FIELD_W'(new_cnt);
      word_out.last_of_run <= b_last;
      word_out.packet_done <= b_last && b_eop;
    end
  end

endmodule

@@ hw/rtl/cobs_stream_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// cobs_stream_encoder_unit
// Streaming COBS encoder: bytes in, code/data groups packed into words out.
//
//   port      | role  | payload
//   ----------+-------+---------------------------------------------------
//   byte_in   | sink  | data_byte[7:0], end_of_packet
//   word_out  | source| out_bytes[63:0], byte_count[3:0], last_of_run,
//             |       | packet_done
//
// The front takes one byte per cycle while the group bank it fills is free.
// The back reads the group RAM one byte a cycle unless the output stalls:
// the code byte, the group's data bytes, then any lone trailing code.
// Two banks let one group fill while the previous one drains; the front
// stalls when both banks still wait for the back, as an output stall may cause.
// Reset clears control state only; the group RAM needs no clearing.
// ----------------------------------------------------------------------------
module cobs_stream_encoder_unit #(
  parameter int unsigned BYTES_PER_RESULT = cse_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cse_in_if.sink     byte_in,
  cse_out_if.source  word_out
);
  import cse_pkg::*;

  ram_wr_t               ram_wr;
  bank_rel_t             bank_rel;
  logic                  q_push;
  cmd_t                  q_cmd;
  logic                  q_pop;
  logic                  q_valid;
  cmd_t                  q_head;
  logic                  q_full;
  logic                  rd_en;
  logic [RAM_ADDR_W-1:0] rd_addr;
  logic [7:0]            rd_data;

  // accept and classify bytes
  cse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .ram_wr   (ram_wr),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .bank_rel (bank_rel)
  );

  // hold flush commands
  cse_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .full       (q_full)
  );

  // two group banks
  cse_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_group_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // emit and pack encoded bytes
  cse_back #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .bank_rel   (bank_rel),
    .word_out   (word_out)
  );

  // a flush never meets a full command queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full && !q_pop))
    else $error("flush command pushed into a full queue");

  // the back never reads the bank the front is writing in the same cycle
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (ram_wr.en && rd_en) |-> (ram_wr.addr[RAM_ADDR_W-1] != rd_addr[RAM_ADDR_W-1]))
    else $error("group bank read and written together");

  // a result word carries between one and the configured number of bytes
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    word_out.valid |-> (word_out.byte_count != '0 &&
                        word_out.byte_count <= CNT_FIELD_W'(BYTES_PER_RESULT)))
    else $error("result byte count out of range");

  // packet end only on the closing word of a run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (word_out.valid && word_out.packet_done) |-> word_out.last_of_run)
    else $error("packet end flagged mid-run");

endmodule

@@ bench/cobs_word_checker.sv @@
// ----------------------------------------------------------------------------
// cobs_word_checker
// Watches the byte and word channels of the COBS stream encoder. It encodes
// every accepted byte in a local model of the group store, queues the words
// it expects, and compares each accepted output word against the oldest one.
// ----------------------------------------------------------------------------
module cobs_word_checker #(
  parameter int unsigned PER_WORD = cse_pkg::BYTES_PER_RESULT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cse_in_if           byte_mon,
  cse_out_if          word_mon,
  output int unsigned mismatches,
  output int unsigned words_pending
);

  typedef struct packed {
    logic [cse_pkg::OUT_W-1:0]       bytes;
    logic [cse_pkg::CNT_FIELD_W-1:0] count;
    logic                            last;
    logic                            done;
  } enc_word_t;

  enc_word_t   expected_words[$];
  logic [7:0]  group_buf[0:cse_pkg::GROUP_MAX-1];
  int unsigned group_fill = 0;
  logic [7:0]  enc_run[$];

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  // close the open group: code byte, then its data bytes
  function automatic void close_group();
    int unsigned i;
    enc_run.push_back(8'(group_fill + 1));
    for (i = 0; i < group_fill; i++) enc_run.push_back(group_buf[i]);
    group_fill = 0;
  endfunction

  // encode one input byte and queue the words it yields
  function automatic void encode_byte(input logic [7:0] b, input logic eop);
    enc_word_t   w;
    int unsigned pos;
    int unsigned n;
    int unsigned k;
    enc_run.delete();
    if (b != 8'h00) begin
      group_buf[group_fill] = b;
      group_fill++;
      if (group_fill == cse_pkg::GROUP_MAX || eop) close_group();
    end else begin
      close_group();
      if (eop) enc_run.push_back(cse_pkg::LONE_CODE);
    end
    pos = 0;
    while (pos < enc_run.size()) begin
      n = enc_run.size() - pos;
      if (n > PER_WORD) n = PER_WORD;
      w = '0;
      for (k = 0; k < n; k++) w.bytes[8*k +: 8] = enc_run[pos + k];
      pos += n;
      w.count = 4'(n);
      w.last  = (pos == enc_run.size());
      w.done  = w.last && eop;
      expected_words.push_back(w);
    end
  endfunction

  // predict on every byte transfer, compare on every word transfer
  always @(posedge clk) begin
    enc_word_t exp_w;
    if (rst) begin
      group_fill = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready)
        encode_byte(byte_mon.data_byte, byte_mon.end_of_packet);
      if (word_mon.valid && word_mon.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, got bytes=%h count=%0d last=%b done=%b",
                   $time, word_mon.out_bytes, word_mon.byte_count,
                   word_mon.last_of_run, word_mon.packet_done);
        end else begin
          exp_w = expected_words.pop_front();
          if (word_mon.out_bytes !== exp_w.bytes || word_mon.byte_count !== exp_w.count ||
              word_mon.last_of_run !== exp_w.last || word_mon.packet_done !== exp_w.done) begin
            mismatches++;
            $display("%0t: word mismatch: expected bytes=%h count=%0d last=%b done=%b",
                     $time, exp_w.bytes, exp_w.count, exp_w.last, exp_w.done);
            $display("%0t:                  actual bytes=%h count=%0d last=%b done=%b",
                     $time, word_mon.out_bytes, word_mon.byte_count,
                     word_mon.last_of_run, word_mon.packet_done);
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

@@ bench/cobs_stream_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cobs_stream_encoder_unit_tb
// Drives packets into the COBS stream encoder: a few hand-picked packets,
// a run of zero bytes against a long output stall, then random packets
// with one full 254-byte group, a zero and packet end right behind it, in
// their midst, random gaps on both channels and drain pauses. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module cobs_stream_encoder_unit_tb;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_ITEMS = 48;
  localparam int unsigned HOLD_ZEROS   = 8;
  localparam int unsigned TAIL_CYCLES  = 16;

  // ways a packet may go on after a full group
  typedef enum int unsigned {
    FULL_AT_END,
    FULL_THEN_ZERO_END,
    FULL_THEN_ZERO,
    FULL_THEN_MORE
  } full_tail_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned pending;
  bit          no_idle;
  bit          hold_words;

  cse_in_if  byte_ch ();
  cse_out_if word_ch ();

  cobs_stream_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .word_out (word_ch)
  );

  cobs_word_checker chk (
    .clk           (clk),
    .rst           (rst),
    .byte_mon      (byte_ch),
    .word_mon      (word_ch),
    .mismatches    (mismatches),
    .words_pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one byte after a random gap, hold until the transfer
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_packet <= eop;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  // stop offering and wait for every expected word
  task automatic drain_words();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // random packet, roughly one byte in four zero
  task automatic send_packet(input int unsigned len);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < len; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // packet opening with a full group of nonzero bytes
  task automatic send_full_group(input full_tail_t tail);
    int unsigned i;
    for (i = 0; i < cse_pkg::GROUP_MAX; i++)
      send_byte(8'($urandom_range(1, 255)), tail == FULL_AT_END && i == cse_pkg::GROUP_MAX - 1);
    case (tail)
      FULL_THEN_ZERO_END: begin
        send_byte(8'h00, 1'b1);
      end
      FULL_THEN_ZERO: begin
        send_byte(8'h00, 1'b0);
        send_packet(3);
      end
      FULL_THEN_MORE: begin
        for (i = 0; i < 4; i++) send_byte(8'($urandom_range(1, 255)), i == 3);
      end
      default: begin
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    rst                   = 1'b1;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = 8'h00;
    byte_ch.end_of_packet = 1'b0;
    no_idle               = 1'b0;
    hold_words            = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // lone zero: empty group then trailing code
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hff, 1'b1);
    // run of zeros
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // zero in the middle
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h33, 1'b1);
    // exactly one full word, then one byte over
    for (i = 0; i < 7; i++) send_byte(8'hff, i == 6);
    for (i = 0; i < 8; i++) send_byte(8'h80, i == 7);
    drain_words();

    // stall the output while zero bytes keep coming, so the input backs up
    hold_words = 1'b1;
    for (i = 0; i < HOLD_ZEROS; i++) send_byte(8'h00, i == HOLD_ZEROS - 1);
    drain_words();

    sent = 0;
    while (sent < RANDOM_ITEMS / 2) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 12);
      send_packet(len);
      sent += len;
    end
    no_idle = 1'b0;

    send_full_group(FULL_THEN_ZERO_END);

    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 12);
      send_packet(len);
      sent += len;
    end
    no_idle = 1'b0;

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // output side: random gaps per word, one long stall on request
  initial begin
    int unsigned gap;
    word_ch.ready = 1'b0;
    forever begin
      if (hold_words) begin
        word_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_words = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        word_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      word_ch.ready <= 1'b1;
      do @(posedge clk); while (word_ch.valid !== 1'b1 && !hold_words);
    end
  end

  // watchdog: give up after a long run of cycles with no transfer
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cse_pkg.sv
hw/rtl/cse_in_if.sv
hw/rtl/cse_out_if.sv
hw/rtl/cse_ram.sv
hw/rtl/cse_front.sv
hw/rtl/cse_cmd_queue.sv
hw/rtl/cse_back.sv
hw/rtl/cobs_stream_encoder_unit.sv
bench/cobs_word_checker.sv
bench/cobs_stream_encoder_unit_tb.sv
